// ----- hw/rtl/mtf_zero_run_symbol_decoder_defines.svh -----
// Assertion macros for the MTF zero-run symbol decoder; clk and rst_n come from the using module.
`ifndef MTF_ZERO_RUN_SYMBOL_DECODER_DEFINES_SVH
`define MTF_ZERO_RUN_SYMBOL_DECODER_DEFINES_SVH

// ante holds -> cons holds in the same cycle
`define MZR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// ante holds -> cons holds in the next cycle
`define MZR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// cond holds at every edge out of reset
`define MZR_ASSERT_INV(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ----- hw/rtl/mzr_pkg.sv -----
// Shared types, codes and constants of the MTF zero-run symbol decoder.
`default_nettype none

package mzr_pkg;

  localparam int unsigned MAX_BLOCK_DEF = 900000;
  localparam int CNT_W = 20;               // run, weight and byte counters

  localparam int LIST_DEPTH = 256;
  localparam int LIST_AW    = 8;

  localparam int CQ_DEPTH  = 2;            // command queue, front to back
  localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);
  localparam int OQ_DEPTH  = 4;            // result queue, back to output
  localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

  // input opcodes
  localparam logic [1:0] OPC_START = 2'd0;
  localparam logic [1:0] OPC_MAP   = 2'd1;
  localparam logic [1:0] OPC_SYM   = 2'd2;

  localparam logic [8:0] SYM_RUNB = 9'd1;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // error causes
  localparam logic [2:0] CAUSE_NONE    = 3'd0;
  localparam logic [2:0] CAUSE_BAD_SYM = 3'd1;
  localparam logic [2:0] CAUSE_RUN_OVF = 3'd2;
  localparam logic [2:0] CAUSE_FULL    = 3'd3;
  localparam logic [2:0] CAUSE_BAD_MAP = 3'd4;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_MAP,
    CMD_RUN,
    CMD_SYM
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [3:0]  map_group;
    logic [15:0] map_bits;
    logic [8:0]  symbol;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       byte_value;
    logic [CNT_W-1:0] repeat_count;
    logic [2:0]       error_cause;
    logic             last;
  } result_t;

  function automatic result_t mk_data(input logic [7:0] b, input logic [CNT_W-1:0] cnt,
                                      input logic lst);
    return '{kind: KIND_DATA, byte_value: b, repeat_count: cnt,
             error_cause: CAUSE_NONE, last: lst};
  endfunction

  function automatic result_t mk_end();
    return '{kind: KIND_END, byte_value: 8'd0, repeat_count: '0,
             error_cause: CAUSE_NONE, last: 1'b1};
  endfunction

  function automatic result_t mk_err(input logic [2:0] cause);
    return '{kind: KIND_ERR, byte_value: 8'd0, repeat_count: '0,
             error_cause: cause, last: 1'b1};
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mzr_if.sv -----
// Valid/ready channel interfaces for the decoder's input and result words.
`default_nettype none

interface mzr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  map_group;
  logic [15:0] map_bits;
  logic [8:0]  symbol;

  modport source (output valid, opcode, map_group, map_bits, symbol, input ready);
  modport sink   (input valid, opcode, map_group, map_bits, symbol, output ready);
endinterface

interface mzr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_value;
  logic [19:0] repeat_count;
  logic [2:0]  error_cause;
  logic        last;

  modport source (output valid, kind, byte_value, repeat_count, error_cause, last,
                  input ready);
  modport sink   (input valid, kind, byte_value, repeat_count, error_cause, last,
                  output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mzr_fifo.sv -----
// Small synchronous FIFO; DEPTH must be a power of two.
`default_nettype none

module mzr_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push_valid,
  input  T                             push_data,
  output logic                         pop_valid,
  input  logic                         pop_ready,
  output T                             pop_data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  T                 slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign do_push   = push_valid && (count_r != CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign do_pop    = pop_valid && pop_ready;
  assign pop_data  = slots_r[rd_ptr_r];
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mzr_front.sv -----
// Front end: takes input words and turns them into back-end commands.
`default_nettype none

module mzr_front import mzr_pkg::*; (
  mzr_in_if.sink in_ch,
  input  logic   cq_room,
  output logic   cq_push,
  output cmd_t   cq_data
);

  logic take;

  assign in_ch.ready = cq_room;
  assign take        = in_ch.valid && cq_room;

  always_comb begin
    cq_data.map_group = in_ch.map_group;
    cq_data.map_bits  = in_ch.map_bits;
    cq_data.symbol    = in_ch.symbol;
    cq_data.op        = CMD_START;
    cq_push           = 1'b0;
    case (in_ch.opcode)
      OPC_START: begin
        cq_data.op = CMD_START;
        cq_push    = take;
      end
      OPC_MAP: begin
        cq_data.op = CMD_MAP;
        cq_push    = take;
      end
      OPC_SYM: begin
        // RUNA / RUNB go to the run counter, everything else to MTF decode
        cq_data.op = (in_ch.symbol <= SYM_RUNB) ? CMD_RUN : CMD_SYM;
        cq_push    = take;
      end
      default: begin
        // reserved opcode: word is taken and dropped
        cq_push = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mzr_back.sv -----
// Back end: block state, MTF list memory, run counting and result generation.
`default_nettype none

`include "mtf_zero_run_symbol_decoder_defines.svh"

module mzr_back import mzr_pkg::*; #(
  parameter int unsigned MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  cmd_t                cmd,
  output logic                cmd_pop,
  input  logic [OQ_CNT_W-1:0] oq_count,
  output logic                res_push,
  output result_t             res
);

  localparam logic [CNT_W-1:0]    MAXV    = CNT_W'(MAX_BLOCK);
  localparam logic [CNT_W-1:0]    HALF    = CNT_W'(MAX_BLOCK / 2);
  localparam logic [CNT_W-1:0]    WT_SAT  = CNT_W'(MAX_BLOCK + 1);
  localparam logic [OQ_CNT_W-1:0] OQ_FULL = OQ_CNT_W'(OQ_DEPTH);
  localparam logic [OQ_CNT_W-1:0] OQ_LOW  = OQ_CNT_W'(OQ_DEPTH - 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_RD,
    S_MOVE,
    S_SECOND
  } state_t;

  state_t             state_r,    state_nxt;
  logic [8:0]         sym_total_r, sym_total_nxt;
  logic [4:0]         last_grp_r, last_grp_nxt;
  logic [CNT_W-1:0]   run_len_r,  run_len_nxt;
  logic [CNT_W-1:0]   run_wt_r,   run_wt_nxt;
  logic               run_pend_r, run_pend_nxt;
  logic [CNT_W-1:0]   bytes_r,    bytes_nxt;
  logic               done_r,     done_nxt;
  logic [7:0]         head_r,     head_nxt;
  logic [15:0]        bits_r,     bits_nxt;
  logic [3:0]         grp_r,      grp_nxt;
  logic [3:0]         lo_r,       lo_nxt;
  logic [LIST_AW-1:0] move_j_r,   move_j_nxt;
  logic [7:0]         val_r,      val_nxt;
  result_t            res2_r,     res2_nxt;

  // MTF list; entry 0 lives in head_r and is never read from here
  logic [7:0]         mtf_mem [LIST_DEPTH];
  logic [7:0]         rdata_r;
  logic               mem_we;
  logic [LIST_AW-1:0] mem_waddr;
  logic [7:0]         mem_wdata;
  logic [LIST_AW-1:0] mem_raddr;

  logic               room2;
  logic [9:0]         total_p1;
  logic               sym_bad;
  logic               is_end;
  logic [LIST_AW-1:0] idx;
  logic               wt_big;
  logic [CNT_W:0]     contrib;
  logic [CNT_W:0]     len_sum;
  logic               len_big;
  logic [CNT_W-1:0]   wt_next;
  logic [CNT_W:0]     byte_sum;
  logic               run_full;
  logic [CNT_W-1:0]   bytes_after;
  logic               lit_full;
  logic               map_bad;
  result_t            r2;
  logic               r2_now;

  assign room2    = (oq_count <= OQ_LOW);
  assign total_p1 = {1'b0, sym_total_r} + 10'd1;
  assign sym_bad  = ({1'b0, cmd.symbol} > total_p1);
  assign is_end   = ({1'b0, cmd.symbol} == total_p1);
  assign idx      = cmd.symbol[LIST_AW-1:0] - LIST_AW'(1);

  // bijective base-2 run: RUNA adds weight, RUNB adds twice the weight
  assign wt_big   = cmd.symbol[0] ? (run_wt_r > HALF) : (run_wt_r > MAXV);
  assign contrib  = cmd.symbol[0] ? {run_wt_r, 1'b0} : {1'b0, run_wt_r};
  assign len_sum  = {1'b0, run_len_r} + contrib;
  assign len_big  = (len_sum > {1'b0, MAXV});
  assign wt_next  = (run_wt_r > HALF) ? WT_SAT : {run_wt_r[CNT_W-2:0], 1'b0};

  assign byte_sum    = {1'b0, bytes_r} + {1'b0, run_len_r};
  assign run_full    = run_pend_r && (byte_sum > {1'b0, MAXV});
  assign bytes_after = run_pend_r ? byte_sum[CNT_W-1:0] : bytes_r;
  assign lit_full    = (bytes_after >= MAXV);

  assign map_bad = done_r || run_pend_r || (bytes_r != '0) ||
                   (!last_grp_r[4] && (cmd.map_group <= last_grp_r[3:0]));

  always_comb begin
    state_nxt     = state_r;
    sym_total_nxt = sym_total_r;
    last_grp_nxt  = last_grp_r;
    run_len_nxt   = run_len_r;
    run_wt_nxt    = run_wt_r;
    run_pend_nxt  = run_pend_r;
    bytes_nxt     = bytes_r;
    done_nxt      = done_r;
    head_nxt      = head_r;
    bits_nxt      = bits_r;
    grp_nxt       = grp_r;
    lo_nxt        = lo_r;
    move_j_nxt    = move_j_r;
    val_nxt       = val_r;
    res2_nxt      = res2_r;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    res           = mk_end();
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = 8'd0;
    mem_raddr     = idx;
    r2            = mk_end();
    r2_now        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid && room2) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            CMD_START: begin
              sym_total_nxt = '0;
              last_grp_nxt  = 5'd16;
              run_len_nxt   = '0;
              run_wt_nxt    = CNT_W'(1);
              run_pend_nxt  = 1'b0;
              bytes_nxt     = '0;
              done_nxt      = 1'b0;
            end
            CMD_MAP: begin
              if (map_bad) begin
                res_push = 1'b1;
                res      = mk_err(CAUSE_BAD_MAP);
                done_nxt = 1'b1;
              end else begin
                last_grp_nxt = {1'b0, cmd.map_group};
                grp_nxt      = cmd.map_group;
                bits_nxt     = cmd.map_bits;
                lo_nxt       = 4'd0;
                state_nxt    = S_MAP;
              end
            end
            default: begin
              // RUNA/RUNB and MTF symbols share the front checks
              if (done_r) begin
                res_push = 1'b1;
                res      = mk_err(CAUSE_BAD_SYM);
                done_nxt = 1'b1;
              end else if (sym_total_r == '0) begin
                res_push = 1'b1;
                res      = mk_err(CAUSE_BAD_MAP);
                done_nxt = 1'b1;
              end else if (sym_bad) begin
                res_push = 1'b1;
                res      = mk_err(CAUSE_BAD_SYM);
                done_nxt = 1'b1;
              end else if (cmd.op == CMD_RUN) begin
                if (wt_big || len_big) begin
                  res_push = 1'b1;
                  res      = mk_err(CAUSE_RUN_OVF);
                  done_nxt = 1'b1;
                end else begin
                  run_len_nxt  = len_sum[CNT_W-1:0];
                  run_wt_nxt   = wt_next;
                  run_pend_nxt = 1'b1;
                end
              end else if (run_full) begin
                res_push = 1'b1;
                res      = mk_err(CAUSE_FULL);
                done_nxt = 1'b1;
              end else begin
                if (run_pend_r) begin
                  res_push     = 1'b1;
                  res          = mk_data(head_r, run_len_r, 1'b0);
                  bytes_nxt    = bytes_after;
                  run_pend_nxt = 1'b0;
                  run_len_nxt  = '0;
                  run_wt_nxt   = CNT_W'(1);
                end
                if (is_end) begin
                  r2       = mk_end();
                  r2_now   = 1'b1;
                  done_nxt = 1'b1;
                end else if (lit_full) begin
                  r2       = mk_err(CAUSE_FULL);
                  r2_now   = 1'b1;
                  done_nxt = 1'b1;
                end else if (idx == '0) begin
                  // front hit: no list movement
                  r2        = mk_data(head_r, CNT_W'(1), 1'b1);
                  r2_now    = 1'b1;
                  bytes_nxt = bytes_after + CNT_W'(1);
                end else begin
                  bytes_nxt  = bytes_after + CNT_W'(1);
                  mem_raddr  = idx;
                  move_j_nxt = idx;
                  state_nxt  = S_RD;
                end
                if (r2_now) begin
                  if (run_pend_r) begin
                    res2_nxt  = r2;
                    state_nxt = S_SECOND;
                  end else begin
                    res_push = 1'b1;
                    res      = r2;
                  end
                end
              end
            end
          endcase
        end
      end

      S_MAP: begin
        // one presence bit per cycle, stops after the last set bit
        if (bits_r[15] && !sym_total_r[8]) begin
          mem_we    = 1'b1;
          mem_waddr = sym_total_r[LIST_AW-1:0];
          mem_wdata = {grp_r, lo_r};
          if (sym_total_r == '0) begin
            head_nxt = {grp_r, lo_r};
          end
          sym_total_nxt = sym_total_r + 9'd1;
        end
        bits_nxt = {bits_r[14:0], 1'b0};
        lo_nxt   = lo_r + 4'd1;
        if (bits_nxt == '0) begin
          state_nxt = S_IDLE;
        end
      end

      S_RD: begin
        val_nxt   = rdata_r;
        res_push  = 1'b1;
        res       = mk_data(rdata_r, CNT_W'(1), 1'b1);
        mem_raddr = move_j_r - LIST_AW'(1);
        state_nxt = S_MOVE;
      end

      S_MOVE: begin
        // shift entries [1..j-1] up by one, top down; read runs one ahead
        mem_we    = 1'b1;
        mem_waddr = move_j_r;
        mem_wdata = (move_j_r == LIST_AW'(1)) ? head_r : rdata_r;
        mem_raddr = move_j_r - LIST_AW'(2);
        if (move_j_r == LIST_AW'(1)) begin
          head_nxt  = val_r;
          state_nxt = S_IDLE;
        end else begin
          move_j_nxt = move_j_r - LIST_AW'(1);
        end
      end

      S_SECOND: begin
        res_push  = 1'b1;
        res       = res2_r;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sym_total_r <= '0;
      last_grp_r  <= 5'd16;
      run_len_r   <= '0;
      run_wt_r    <= CNT_W'(1);
      run_pend_r  <= 1'b0;
      bytes_r     <= '0;
      done_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sym_total_r <= sym_total_nxt;
      last_grp_r  <= last_grp_nxt;
      run_len_r   <= run_len_nxt;
      run_wt_r    <= run_wt_nxt;
      run_pend_r  <= run_pend_nxt;
      bytes_r     <= bytes_nxt;
      done_r      <= done_nxt;
    end
    head_r   <= head_nxt;
    bits_r   <= bits_nxt;
    grp_r    <= grp_nxt;
    lo_r     <= lo_nxt;
    move_j_r <= move_j_nxt;
    val_r    <= val_nxt;
    res2_r   <= res2_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mtf_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mtf_mem[mem_raddr];
  end

  `MZR_ASSERT_IMP(a_oq_room, res_push, oq_count != OQ_FULL, "result pushed into full queue")
  `MZR_ASSERT_IMP(a_run_map, run_pend_r, sym_total_r != '0, "run pending with empty map")
  `MZR_ASSERT_IMP(a_run_len, run_pend_r, run_len_r != '0, "run pending with zero length")
  `MZR_ASSERT_INV(a_bytes_max, bytes_r <= MAXV, "byte count past block size")
  `MZR_ASSERT_NXT(a_move_end, state_r == S_MOVE && move_j_r == LIST_AW'(1), state_r == S_IDLE, "list move did not finish")

endmodule

`default_nettype wire

// ----- hw/rtl/mtf_zero_run_symbol_decoder.sv -----
// bzip2 MTF / zero-run symbol decoder, top level.
//
// Channels: in_ch takes start, map and symbol words; out_ch gives data, end and error
// words (valid/ready, a word moves on an edge with both high). No config port.
// Front classifies input words into a 2-entry command queue; back executes them
// against the block state and the 256-entry MTF list memory and writes results into
// a 4-entry result queue that drives out_ch.
// With the back end idle, the first result of a word passes the command queue and
// the result queue; an MTF literal below the list front with no pending run
// also waits for a list read first. Back-end handling per word:
//   start, RUNA/RUNB, end symbol, errors: done on taking the word
//   run flushed ahead of an end, block-full error or front-hit literal: S_SECOND follows
//   MTF symbol at list position k > 0: list read, then k entries moved, one per cycle
//     through the single write port of the list memory
//   map word: presence bits scanned up to its last set bit (one bit per cycle)
// Reset clears the block state as a start word would; the MTF list memory is not
// cleared, it is filled by map words before any read.
// Receiver stall: results wait in the result queue; the back end takes a new word only
// when two result slots are free, then the command queue fills and in_ch.ready drops.
`default_nettype none

module mtf_zero_run_symbol_decoder import mzr_pkg::*; #(
  parameter int unsigned MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mzr_in_if.sink    in_ch,
  mzr_out_if.source out_ch
);

  logic                cq_push;
  cmd_t                cq_data;
  logic                cq_valid;
  logic                cq_pop;
  cmd_t                cq_head;
  logic [CQ_CNT_W-1:0] cq_count;
  logic                cq_room;

  logic                res_push;
  result_t             res_data;
  logic                oq_valid;
  result_t             oq_head;
  logic [OQ_CNT_W-1:0] oq_count;

  assign cq_room = (cq_count != CQ_CNT_W'(CQ_DEPTH));

  mzr_front u_front (
    .in_ch   (in_ch),
    .cq_room (cq_room),
    .cq_push (cq_push),
    .cq_data (cq_data)
  );

  mzr_fifo #(
    .T     (cmd_t),
    .DEPTH (CQ_DEPTH)
  ) u_cmd_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (cq_push),
    .push_data  (cq_data),
    .pop_valid  (cq_valid),
    .pop_ready  (cq_pop),
    .pop_data   (cq_head),
    .count      (cq_count)
  );

  mzr_back #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cq_valid),
    .cmd       (cq_head),
    .cmd_pop   (cq_pop),
    .oq_count  (oq_count),
    .res_push  (res_push),
    .res       (res_data)
  );

  mzr_fifo #(
    .T     (result_t),
    .DEPTH (OQ_DEPTH)
  ) u_res_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_push),
    .push_data  (res_data),
    .pop_valid  (oq_valid),
    .pop_ready  (out_ch.ready),
    .pop_data   (oq_head),
    .count      (oq_count)
  );

  assign out_ch.valid        = oq_valid;
  assign out_ch.kind         = oq_head.kind;
  assign out_ch.byte_value   = oq_head.byte_value;
  assign out_ch.repeat_count = oq_head.repeat_count;
  assign out_ch.error_cause  = oq_head.error_cause;
  assign out_ch.last         = oq_head.last;

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the bzip2 MTF / zero-run symbol decoder.
import mzr_pkg::*;

localparam logic [1:0] OPC_UNUSED = 2'd3;
localparam logic [8:0] SYM_RUNA   = 9'd0;
localparam logic [4:0] NO_GROUP   = 5'd16;

typedef struct {
  logic [1:0]  opcode;
  logic [3:0]  group;
  logic [15:0] bits;
  logic [8:0]  symbol;
} in_word_t;

// Tracks block state, works out the result words each input word causes, and
// checks the decoder's result words against them in order.
class mtf_decode_scoreboard;
  bit [7:0]    order_list [256];
  bit [8:0]    sym_count;
  bit [4:0]    top_group;
  bit [19:0]   run_len;
  bit [19:0]   run_wt;
  bit [19:0]   emitted;
  bit          run_open;
  bit          closed;
  int unsigned max_blk;
  result_t     fresh [$];
  result_t     awaited [$];
  int          bad_words;

  function new(int unsigned limit);
    max_blk = limit;
    bad_words = 0;
    clear_block();
  endfunction

  function void clear_block();
    foreach (order_list[i]) order_list[i] = 8'd0;
    sym_count = '0;
    top_group = NO_GROUP;
    run_len   = '0;
    run_wt    = 20'd1;
    emitted   = '0;
    run_open  = 1'b0;
    closed    = 1'b0;
  endfunction

  function void emit(bit [1:0] kind, bit [7:0] b, bit [19:0] cnt, bit [2:0] cause);
    result_t r;
    r.kind = kind;
    r.byte_value = b;
    r.repeat_count = cnt;
    r.error_cause = cause;
    r.last = 1'b0;
    fresh.push_back(r);
  endfunction

  function void abort_block(bit [2:0] cause);
    closed = 1'b1;
    emit(KIND_ERR, 8'd0, 20'd0, cause);
  endfunction

  function void map_word(bit [3:0] g, bit [15:0] bits);
    if (closed || run_open || emitted != 0 || (top_group != NO_GROUP && g <= top_group)) begin
      abort_block(CAUSE_BAD_MAP);
      return;
    end
    top_group = g;
    for (int lo = 0; lo < 16; lo++) begin
      if (bits[15 - lo] && sym_count < 256) begin
        order_list[sym_count] = 8'(g * 16 + lo);
        sym_count++;
      end
    end
  endfunction

  function void symbol_word(bit [8:0] s);
    int unsigned n;
    int unsigned mult;
    int unsigned contrib;
    int unsigned idx;
    bit [7:0]    val;
    n = sym_count;
    if (closed) begin
      abort_block(CAUSE_BAD_SYM);
      return;
    end
    if (n == 0) begin
      abort_block(CAUSE_BAD_MAP);
      return;
    end
    if (s > n + 1) begin
      abort_block(CAUSE_BAD_SYM);
      return;
    end
    // RUNA / RUNB: one digit of the bijective base-2 run count
    if (s <= SYM_RUNB) begin
      mult = s + 1;
      if (run_wt > max_blk / mult) begin
        abort_block(CAUSE_RUN_OVF);
        return;
      end
      contrib = run_wt * mult;
      if (run_len > max_blk - contrib) begin
        abort_block(CAUSE_RUN_OVF);
        return;
      end
      run_len += contrib;
      run_wt = (run_wt > max_blk / 2) ? max_blk + 1 : run_wt << 1;
      run_open = 1'b1;
      return;
    end
    // any other symbol flushes a pending run first
    if (run_open) begin
      if (run_len > max_blk - emitted) begin
        abort_block(CAUSE_FULL);
        return;
      end
      emit(KIND_DATA, order_list[0], run_len, CAUSE_NONE);
      emitted += run_len;
      run_open = 1'b0;
      run_len = '0;
      run_wt = 20'd1;
    end
    if (s == n + 1) begin
      closed = 1'b1;
      emit(KIND_END, 8'd0, 20'd0, CAUSE_NONE);
      return;
    end
    idx = (s - 1) & 8'hFF;
    val = order_list[idx];
    for (int i = idx; i > 0; i--) order_list[i] = order_list[i - 1];
    order_list[0] = val;
    if (emitted >= max_blk) begin
      abort_block(CAUSE_FULL);
      return;
    end
    emitted++;
    emit(KIND_DATA, val, 20'd1, CAUSE_NONE);
  endfunction

  // called for every input word taken by the decoder
  function void note_word(in_word_t w);
    fresh.delete();
    case (w.opcode)
      OPC_START: clear_block();
      OPC_MAP:   map_word(w.group, w.bits);
      OPC_SYM:   symbol_word(w.symbol);
      default: ;
    endcase
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[i]) awaited.push_back(fresh[i]);
  endfunction

  // called for every result word taken from the decoder
  function void check_word(result_t got);
    result_t want;
    if (awaited.size() == 0) begin
      bad_words++;
      if (bad_words <= 10)
        $display("unexpected result: kind %0d byte %0d count %0d cause %0d last %0d",
                 got.kind, got.byte_value, got.repeat_count, got.error_cause, got.last);
      return;
    end
    want = awaited.pop_front();
    if (got.kind !== want.kind || got.byte_value !== want.byte_value ||
        got.repeat_count !== want.repeat_count || got.error_cause !== want.error_cause ||
        got.last !== want.last) begin
      bad_words++;
      if (bad_words <= 10)
        $display("result mismatch: expected kind %0d byte %0d count %0d cause %0d last %0d, got kind %0d byte %0d count %0d cause %0d last %0d",
                 want.kind, want.byte_value, want.repeat_count, want.error_cause, want.last,
                 got.kind, got.byte_value, got.repeat_count, got.error_cause, got.last);
    end
  endfunction
endclass

module testbench;
  localparam int unsigned MAX_BLK = MAX_BLOCK_DEF;
  localparam int TOTAL_WORDS  = 650;
  localparam int QUIET_TAIL   = 80;     // no idling on either side for the last words
  localparam int HOLD_AT      = 150;    // word index where the long receiver hold starts
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 300;    // covers the slowest word: deep MTF hit
  // timeout for the whole run, in simulation time units
  localparam longint TIMEOUT_UNITS = 64'd12_000_000;

  logic clk = 1'b0;
  logic rst_n;

  mzr_in_if  in_ch ();
  mzr_out_if out_ch ();

  mtf_zero_run_symbol_decoder #(.MAX_BLOCK(MAX_BLK)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  mtf_decode_scoreboard book = new(MAX_BLK);

  in_word_t plan [$];
  int       idle_odds = 3;    // 0: no idling, else one chance in idle_odds+1 per word
  bit       hold_req  = 1'b0;

  function automatic void add(logic [1:0] op, logic [3:0] g, logic [15:0] bits,
                              logic [8:0] s);
    in_word_t w;
    w.opcode = op;
    w.group  = g;
    w.bits   = bits;
    w.symbol = s;
    plan.push_back(w);
  endfunction

  // run count as RUNA/RUNB digits, least significant first
  function automatic void add_run(int unsigned count);
    while (count > 0) begin
      if (count % 2) begin
        add(OPC_SYM, 4'd0, 16'd0, SYM_RUNA);
        count = (count - 1) / 2;
      end else begin
        add(OPC_SYM, 4'd0, 16'd0, SYM_RUNB);
        count = (count - 2) / 2;
      end
    end
  endfunction

  // one well-formed block with random content, sprinkled with noise words
  function automatic void plan_block();
    int unsigned n;
    int unsigned cnt;
    int unsigned top;
    int          r;
    int          syms;
    int          picked;
    bit          heavy;
    bit          full_map;
    logic [15:0] bits;
    add(OPC_START, 4'd0, 16'd0, 9'd0);
    full_map = ($urandom_range(0, 9) == 0);
    heavy    = ($urandom_range(0, 5) == 0);
    n = 0;
    picked = 0;
    for (int g = 0; g < 16; g++) begin
      if (full_map || $urandom_range(0, 7) == 0 || (g == 15 && picked == 0)) begin
        case ($urandom_range(0, 7))
          0:       bits = 16'h0000;
          1:       bits = 16'hFFFF;
          default: bits = 16'($urandom_range(0, 65535));
        endcase
        add(OPC_MAP, 4'(g), bits, 9'd0);
        n += $countones(bits);
        picked++;
      end
    end
    syms = $urandom_range(4, 24);
    for (int k = 0; k < syms; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        // heavy blocks push toward the block-size and run-count limits
        if (heavy) begin
          case ($urandom_range(0, 7))
            0:       cnt = MAX_BLK;
            1:       cnt = $urandom_range(MAX_BLK + 1, 1048575);
            default: cnt = $urandom_range(100000, MAX_BLK);
          endcase
        end else if ($urandom_range(0, 19) == 0) begin
          cnt = $urandom_range(1000, 1048575);
        end else begin
          cnt = $urandom_range(1, 40);
        end
        add_run(cnt);
      end else if (r < 90) begin
        if ($urandom_range(0, 5) == 0) top = n + 1;
        else top = (n + 1 < 9) ? n + 1 : 9;
        add(OPC_SYM, 4'd0, 16'd0, 9'($urandom_range(2, (top < 2) ? 2 : top)));
      end else begin
        add(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
            16'($urandom_range(0, 65535)), 9'($urandom_range(0, 511)));
      end
    end
    add(OPC_SYM, 4'd0, 16'd0, 9'(n + 1));
  endfunction

  // offer one word, optionally after an idle burst, and wait for the handshake
  task automatic send_word(input in_word_t w);
    if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= w.opcode;
    in_ch.map_group <= w.group;
    in_ch.map_bits  <= w.bits;
    in_ch.symbol    <= w.symbol;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    book.note_word(w);
  endtask

  // result side: checks taken words, stalls in bursts, and does the long hold
  initial begin
    int  stall_left;
    int  hold_left;
    bit  take;
    result_t r;
    stall_left = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        r.kind = out_ch.kind;
        r.byte_value = out_ch.byte_value;
        r.repeat_count = out_ch.repeat_count;
        r.error_cause = out_ch.error_cause;
        r.last = out_ch.last;
        book.check_word(r);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      out_ch.ready <= take;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= OPC_START;
    in_ch.map_group <= 4'd0;
    in_ch.map_bits  <= 16'd0;
    in_ch.symbol    <= 9'd0;

    // directed words
    add(OPC_SYM, 4'd0, 16'd0, 9'd2);             // symbol with an empty map
    add(OPC_UNUSED, 4'd15, 16'hFFFF, 9'd511);    // unused opcode, no result
    add(OPC_START, 4'd0, 16'd0, 9'd0);
    add(OPC_MAP, 4'd0, 16'h0000, 9'd0);          // empty map word, accepted
    add(OPC_MAP, 4'd0, 16'hFFFF, 9'd0);          // group not above the last one
    add(OPC_SYM, 4'd0, 16'd0, SYM_RUNA);         // symbol after the block ended
    add(OPC_MAP, 4'd5, 16'h1234, 9'd0);          // map word after the block ended
    add(OPC_START, 4'd0, 16'd0, 9'd0);
    add(OPC_MAP, 4'd0, 16'hFFFF, 9'd0);
    add(OPC_MAP, 4'd15, 16'hFFFF, 9'd0);         // 32 symbols
    add(OPC_SYM, 4'd0, 16'd0, SYM_RUNA);
    add(OPC_SYM, 4'd0, 16'd0, SYM_RUNB);         // run of five
    add(OPC_SYM, 4'd0, 16'd0, 9'd2);             // run flush plus literal
    add(OPC_SYM, 4'd0, 16'd0, 9'd32);            // deepest entry
    add(OPC_SYM, 4'd0, 16'd0, SYM_RUNA);
    add(OPC_SYM, 4'd0, 16'd0, 9'd257);           // bad symbol drops the pending run
    add(OPC_START, 4'd0, 16'd0, 9'd0);
    add(OPC_MAP, 4'd7, 16'h0001, 9'd0);
    add(OPC_MAP, 4'd8, 16'h8000, 9'd0);
    add(OPC_SYM, 4'd0, 16'd0, 9'd2);
    add(OPC_SYM, 4'd0, 16'd0, SYM_RUNB);
    add(OPC_MAP, 4'd9, 16'h00FF, 9'd0);          // map word with a run pending
    add(OPC_START, 4'd0, 16'd0, 9'd0);
    add(OPC_MAP, 4'd1, 16'h4000, 9'd0);
    add(OPC_SYM, 4'd0, 16'd0, 9'd2);             // one symbol: 2 is end of block
    add(OPC_MAP, 4'd2, 16'h8000, 9'd0);          // map word after the end

    while (plan.size() < TOTAL_WORDS) plan_block();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_odds = 0;
          1: idle_odds = 2;
          default: idle_odds = 5;
        endcase
      end
      if (i >= plan.size() - QUIET_TAIL) idle_odds = 0;
      if (i == HOLD_AT) hold_req = 1'b1;
      send_word(plan[i]);
    end
    in_ch.valid <= 1'b0;

    while (book.awaited.size() != 0) @(posedge clk);
    // the decoder may still be busy on words that cause no result
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (book.bad_words == 0 && book.awaited.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
